// ===== hw/rtl/qrs_pkg.sv =====
// ============================================================================
// qrs_pkg: shared types and constants of the quadratic root solver
// Holds the widths that follow from the coefficient width, the status codes
// and the item that travels from the front end through the queue.
// ============================================================================
`default_nettype none

package qrs_pkg;

    localparam int COEF_WIDTH = 16;
    localparam int ROOT_WIDTH = 32;
    // Fractional shift applied to the discriminant before the square root.
    localparam int RAD_SHIFT  = 30;
    // Fractional shift applied to -b to line it up with the square root.
    localparam int B_SHIFT    = 15;

    // Signed discriminant B*B - 4*A*C and its non-negative magnitude.
    localparam int DISC_SWIDTH = 2 * COEF_WIDTH + 2;
    localparam int DISC_WIDTH  = 2 * COEF_WIDTH + 1;
    localparam int RAD_WIDTH   = DISC_WIDTH + RAD_SHIFT;
    localparam int SQRT_STEPS  = (RAD_WIDTH + 1) / 2;
    localparam int RAD_PAD     = 2 * SQRT_STEPS;
    localparam int SQ_REM_WIDTH = SQRT_STEPS + 4;

    // Magnitude of the rounded numerator, and its signed form.
    localparam int NUM_WIDTH  = (SQRT_STEPS >= COEF_WIDTH + B_SHIFT - 1) ?
                                SQRT_STEPS + 2 : COEF_WIDTH + B_SHIFT + 2;
    localparam int NUM_SWIDTH = NUM_WIDTH + 1;

    typedef enum logic [1:0] {
        ST_REAL    = 2'd0,
        ST_COMPLEX = 2'd1,
        ST_DEGEN   = 2'd2
    } status_t;

    typedef struct packed {
        status_t                       status;
        logic signed [COEF_WIDTH-1:0]  a;
        logic signed [COEF_WIDTH-1:0]  b;
        logic [DISC_WIDTH-1:0]         disc;
    } fq_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/qrs_front.sv =====
// ============================================================================
// qrs_front: coefficient intake and classification
// Two stages: the products B*B and A*C, then the discriminant and the
// status of the equation. Hands one item per cycle to the queue while the queue is ready.
// ============================================================================
`default_nettype none

module qrs_front
    import qrs_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic signed [COEF_WIDTH-1:0] coef_a,
    input  wire logic signed [COEF_WIDTH-1:0] coef_b,
    input  wire logic signed [COEF_WIDTH-1:0] coef_c,
    output logic                             item_valid,
    input  wire logic                        item_ready,
    output fq_item_t                         item
);

    logic                            adv;
    logic                            s1_valid_reg;
    logic signed [COEF_WIDTH-1:0]    s1_a_reg;
    logic signed [COEF_WIDTH-1:0]    s1_b_reg;
    logic signed [2*COEF_WIDTH-1:0]  s1_bb_reg;
    logic signed [2*COEF_WIDTH-1:0]  s1_ac_reg;
    logic                            s2_valid_reg;
    fq_item_t                        s2_item_reg;
    fq_item_t                        s2_item_next;
    logic signed [DISC_SWIDTH-1:0]   disc_s;

    assign adv      = !s2_valid_reg || item_ready;
    assign in_ready = adv;

    always_comb
    begin
        disc_s = DISC_SWIDTH'(s1_bb_reg) - (DISC_SWIDTH'(s1_ac_reg) <<< 2);
        s2_item_next.a    = s1_a_reg;
        s2_item_next.b    = s1_b_reg;
        s2_item_next.disc = '0;
        if (s1_a_reg == '0)
        begin
            s2_item_next.status = ST_DEGEN;
        end
        else if (disc_s[DISC_SWIDTH-1])
        begin
            s2_item_next.status = ST_COMPLEX;
        end
        else
        begin
            s2_item_next.status = ST_REAL;
            s2_item_next.disc   = disc_s[DISC_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_a_reg    <= coef_a;
            s1_b_reg    <= coef_b;
            s1_bb_reg   <= (2*COEF_WIDTH)'(coef_b) * (2*COEF_WIDTH)'(coef_b);
            s1_ac_reg   <= (2*COEF_WIDTH)'(coef_a) * (2*COEF_WIDTH)'(coef_c);
            s2_item_reg <= s2_item_next;
        end
    end

    assign item_valid = s2_valid_reg;
    assign item       = s2_item_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/qrs_queue.sv =====
// ============================================================================
// qrs_queue: two-entry queue between front end and back end
// Lets either side stall without at once holding up the other.
// ============================================================================
`default_nettype none

module qrs_queue
    import qrs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push_valid,
    output logic          push_ready,
    input  wire fq_item_t push_item,
    output logic          pop_valid,
    input  wire logic     pop_ready,
    output fq_item_t      pop_item
);

    fq_item_t   mem_reg [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/qrs_back.sv =====
// ============================================================================
// qrs_back: square root, division and saturation pipeline
// One root bit per stage for the square root, a numerator stage, one quotient
// bit per stage for both rounded divisions, then saturation into the output.
// ============================================================================
`default_nettype none

module qrs_back
    import qrs_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         item_valid,
    output logic                              item_ready,
    input  wire fq_item_t                     item,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [1:0]                        root_status,
    output logic signed [ROOT_WIDTH-1:0]      root_plus,
    output logic signed [ROOT_WIDTH-1:0]      root_minus
);

    localparam logic [NUM_WIDTH-1:0] Q_POS_LIM = NUM_WIDTH'(64'h7FFF_FFFF);
    localparam logic [NUM_WIDTH-1:0] Q_NEG_LIM = NUM_WIDTH'(64'h8000_0000);

    logic adv;

    // Square root stages.
    logic                          sq_valid_reg  [0:SQRT_STEPS];
    status_t                       sq_status_reg [0:SQRT_STEPS];
    logic signed [COEF_WIDTH-1:0]  sq_a_reg      [0:SQRT_STEPS];
    logic signed [COEF_WIDTH-1:0]  sq_b_reg      [0:SQRT_STEPS];
    logic [RAD_PAD-1:0]            sq_x_reg      [0:SQRT_STEPS];
    logic [SQ_REM_WIDTH-1:0]       sq_rem_reg    [0:SQRT_STEPS];
    logic [SQRT_STEPS-1:0]         sq_root_reg   [0:SQRT_STEPS];

    // Numerator stage.
    logic                          nm_valid_reg;
    status_t                       nm_status_reg;
    logic [COEF_WIDTH-1:0]         nm_div_reg;
    logic                          nm_neg_p_reg;
    logic                          nm_neg_m_reg;
    logic [NUM_WIDTH-1:0]          nm_mp_reg;
    logic [NUM_WIDTH-1:0]          nm_mm_reg;

    // Division stages.
    logic                          dv_valid_reg  [0:NUM_WIDTH];
    status_t                       dv_status_reg [0:NUM_WIDTH];
    logic [COEF_WIDTH-1:0]         dv_div_reg    [0:NUM_WIDTH];
    logic                          dv_neg_p_reg  [0:NUM_WIDTH];
    logic                          dv_neg_m_reg  [0:NUM_WIDTH];
    logic [NUM_WIDTH-1:0]          dv_mp_reg     [0:NUM_WIDTH];
    logic [NUM_WIDTH-1:0]          dv_mm_reg     [0:NUM_WIDTH];
    logic [COEF_WIDTH-1:0]         dv_rp_reg     [0:NUM_WIDTH];
    logic [COEF_WIDTH-1:0]         dv_rm_reg     [0:NUM_WIDTH];

    // Output register.
    logic                          out_valid_reg;
    status_t                       out_status_reg;
    logic [ROOT_WIDTH-1:0]         out_plus_reg;
    logic [ROOT_WIDTH-1:0]         out_minus_reg;

    logic [COEF_WIDTH-1:0]         a_mag;
    logic signed [NUM_SWIDTH-1:0]  base;
    logic signed [NUM_SWIDTH-1:0]  n_p;
    logic signed [NUM_SWIDTH-1:0]  n_m;
    logic [NUM_WIDTH-1:0]          mp_next;
    logic [NUM_WIDTH-1:0]          mm_next;
    logic [ROOT_WIDTH-1:0]         plus_next;
    logic [ROOT_WIDTH-1:0]         minus_next;

    assign adv        = !out_valid_reg || out_ready;
    assign item_ready = adv;

    // ---------------------------------------------------------------- entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            sq_valid_reg[0] <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_status_reg[0] <= item.status;
            sq_a_reg[0]      <= item.a;
            sq_b_reg[0]      <= item.b;
            sq_x_reg[0]      <= RAD_PAD'({item.disc, RAD_SHIFT'(0)});
            sq_rem_reg[0]    <= '0;
            sq_root_reg[0]   <= '0;
        end
    end

    // ---------------------------------------------------------- square root
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        logic [SQ_REM_WIDTH-1:0] rem_sh;
        logic [SQ_REM_WIDTH-1:0] trial;
        logic                    ge;

        always_comb
        begin
            rem_sh = {sq_rem_reg[k][SQ_REM_WIDTH-3:0], sq_x_reg[k][RAD_PAD-1 -: 2]};
            trial  = {2'b00, sq_root_reg[k], 2'b01};
            ge     = (rem_sh >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_status_reg[k+1] <= sq_status_reg[k];
                sq_a_reg[k+1]      <= sq_a_reg[k];
                sq_b_reg[k+1]      <= sq_b_reg[k];
                sq_x_reg[k+1]      <= sq_x_reg[k] << 2;
                sq_rem_reg[k+1]    <= ge ? (rem_sh - trial) : rem_sh;
                sq_root_reg[k+1]   <= {sq_root_reg[k][SQRT_STEPS-2:0], ge};
            end
        end
    end

    // ------------------------------------------------------------ numerator
    // N = -B * 2^15 +/- S, then |N| + floor(|A| / 2) for rounding to nearest.
    always_comb
    begin
        a_mag = sq_a_reg[SQRT_STEPS][COEF_WIDTH-1] ?
                COEF_WIDTH'(~sq_a_reg[SQRT_STEPS] + 1'b1) :
                COEF_WIDTH'(sq_a_reg[SQRT_STEPS]);
        base  = -(NUM_SWIDTH'(sq_b_reg[SQRT_STEPS]) <<< B_SHIFT);
        n_p   = base + $signed({1'b0, NUM_WIDTH'(sq_root_reg[SQRT_STEPS])});
        n_m   = base - $signed({1'b0, NUM_WIDTH'(sq_root_reg[SQRT_STEPS])});
        mp_next = (n_p[NUM_SWIDTH-1] ? NUM_WIDTH'(-n_p) : NUM_WIDTH'(n_p))
                  + NUM_WIDTH'(a_mag >> 1);
        mm_next = (n_m[NUM_SWIDTH-1] ? NUM_WIDTH'(-n_m) : NUM_WIDTH'(n_m))
                  + NUM_WIDTH'(a_mag >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nm_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            nm_valid_reg <= sq_valid_reg[SQRT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nm_status_reg <= sq_status_reg[SQRT_STEPS];
            nm_div_reg    <= a_mag;
            nm_neg_p_reg  <= n_p[NUM_SWIDTH-1] ^ sq_a_reg[SQRT_STEPS][COEF_WIDTH-1];
            nm_neg_m_reg  <= n_m[NUM_SWIDTH-1] ^ sq_a_reg[SQRT_STEPS][COEF_WIDTH-1];
            nm_mp_reg     <= mp_next;
            nm_mm_reg     <= mm_next;
        end
    end

    always_comb
    begin
        dv_valid_reg[0]  = nm_valid_reg;
        dv_status_reg[0] = nm_status_reg;
        dv_div_reg[0]    = nm_div_reg;
        dv_neg_p_reg[0]  = nm_neg_p_reg;
        dv_neg_m_reg[0]  = nm_neg_m_reg;
        dv_mp_reg[0]     = nm_mp_reg;
        dv_mm_reg[0]     = nm_mm_reg;
        dv_rp_reg[0]     = '0;
        dv_rm_reg[0]     = '0;
    end

    // ------------------------------------------------------------- division
    // Restoring division; the dividend register fills with quotient bits.
    for (genvar j = 0; j < NUM_WIDTH; j++)
    begin : g_div
        logic [COEF_WIDTH:0] rp_sh;
        logic [COEF_WIDTH:0] rm_sh;
        logic                ge_p;
        logic                ge_m;

        always_comb
        begin
            rp_sh = {dv_rp_reg[j], dv_mp_reg[j][NUM_WIDTH-1]};
            rm_sh = {dv_rm_reg[j], dv_mm_reg[j][NUM_WIDTH-1]};
            ge_p  = (rp_sh >= {1'b0, dv_div_reg[j]});
            ge_m  = (rm_sh >= {1'b0, dv_div_reg[j]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_status_reg[j+1] <= dv_status_reg[j];
                dv_div_reg[j+1]    <= dv_div_reg[j];
                dv_neg_p_reg[j+1]  <= dv_neg_p_reg[j];
                dv_neg_m_reg[j+1]  <= dv_neg_m_reg[j];
                dv_mp_reg[j+1]     <= {dv_mp_reg[j][NUM_WIDTH-2:0], ge_p};
                dv_mm_reg[j+1]     <= {dv_mm_reg[j][NUM_WIDTH-2:0], ge_m};
                dv_rp_reg[j+1]     <= ge_p ? COEF_WIDTH'(rp_sh - {1'b0, dv_div_reg[j]})
                                           : COEF_WIDTH'(rp_sh);
                dv_rm_reg[j+1]     <= ge_m ? COEF_WIDTH'(rm_sh - {1'b0, dv_div_reg[j]})
                                           : COEF_WIDTH'(rm_sh);
            end
        end
    end

    // ----------------------------------------------------------- saturation
    always_comb
    begin
        if (dv_neg_p_reg[NUM_WIDTH])
        begin
            plus_next = (dv_mp_reg[NUM_WIDTH] > Q_NEG_LIM) ? ROOT_WIDTH'(Q_NEG_LIM)
                        : ROOT_WIDTH'(-dv_mp_reg[NUM_WIDTH]);
        end
        else
        begin
            plus_next = (dv_mp_reg[NUM_WIDTH] > Q_POS_LIM) ? ROOT_WIDTH'(Q_POS_LIM)
                        : ROOT_WIDTH'(dv_mp_reg[NUM_WIDTH]);
        end
        if (dv_neg_m_reg[NUM_WIDTH])
        begin
            minus_next = (dv_mm_reg[NUM_WIDTH] > Q_NEG_LIM) ? ROOT_WIDTH'(Q_NEG_LIM)
                         : ROOT_WIDTH'(-dv_mm_reg[NUM_WIDTH]);
        end
        else
        begin
            minus_next = (dv_mm_reg[NUM_WIDTH] > Q_POS_LIM) ? ROOT_WIDTH'(Q_POS_LIM)
                         : ROOT_WIDTH'(dv_mm_reg[NUM_WIDTH]);
        end
        if (dv_status_reg[NUM_WIDTH] != ST_REAL)
        begin
            plus_next  = '0;
            minus_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_valid_reg[NUM_WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_status_reg <= dv_status_reg[NUM_WIDTH];
            out_plus_reg   <= plus_next;
            out_minus_reg  <= minus_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign root_status = out_status_reg;
    assign root_plus   = $signed(out_plus_reg);
    assign root_minus  = $signed(out_minus_reg);

endmodule

`default_nettype wire

// ===== hw/rtl/quadratic_root_solver.sv =====
// ============================================================================
// quadratic_root_solver: real roots of a*x^2 + b*x + c = 0
// Takes signed Q8.8 coefficients and returns both real roots in signed
// Q16.16, rounded to nearest and saturated, or a status for complex roots
// or a zero leading coefficient.
// ============================================================================
//
//   Channel   Handshake             Payload
//   input     in_valid / in_ready   coef_a, coef_b, coef_c
//   output    out_valid / out_ready root_status, root_plus, root_minus
//
// One item is accepted per cycle and one result leaves per cycle while the output does not stall.
// The result passes through the first and second front stages, the queue, the
// back end's entry register, the bit-per-stage square root, the numerator
// stage, the bit-per-stage rounded divisions and the output register.
// Reset clears only the valid flags and the queue's pointers and count; the
// block is ready in the first cycle after reset.
// An output stall holds the back pipeline; the two-entry queue absorbs up to
// two of the front end's items before the front end stalls in turn.
`default_nettype none

module quadratic_root_solver
    import qrs_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [COEF_WIDTH-1:0] coef_a,
    input  wire logic signed [COEF_WIDTH-1:0] coef_b,
    input  wire logic signed [COEF_WIDTH-1:0] coef_c,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [1:0]                        root_status,
    output logic signed [ROOT_WIDTH-1:0]      root_plus,
    output logic signed [ROOT_WIDTH-1:0]      root_minus
);

    // Front end to queue.
    logic     fr_valid;
    logic     fr_ready;
    fq_item_t fr_item;

    // Queue to back end.
    logic     bk_valid;
    logic     bk_ready;
    fq_item_t bk_item;

    // Front end: products, discriminant and classification of each item.
    qrs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .coef_a     (coef_a),
        .coef_b     (coef_b),
        .coef_c     (coef_c),
        .item_valid (fr_valid),
        .item_ready (fr_ready),
        .item       (fr_item)
    );

    // Short queue decoupling the two halves.
    qrs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_item  (fr_item),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_item   (bk_item)
    );

    // Back end: square root, two rounded divisions, saturation.
    qrs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (bk_valid),
        .item_ready  (bk_ready),
        .item        (bk_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .root_status (root_status),
        .root_plus   (root_plus),
        .root_minus  (root_minus)
    );

endmodule

`default_nettype wire
